@@ rtl/strided_2d_dma_command_generator_assert.svh @@
// Assertion macros shared by the strided 2D DMA command generator modules.
// Depends on nothing; included by the controller and the datapath.
`ifndef STRIDED_2D_DMA_COMMAND_GENERATOR_ASSERT_SVH
`define STRIDED_2D_DMA_COMMAND_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define S2DMA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define S2DMA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/s2dma_pkg.sv @@
// Shared constants, types and control structs of the strided 2D DMA command generator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package s2dma_pkg;

   localparam int ADDR_W     = 64;
   localparam int DATA_W     = 64;
   localparam int NARROW_W   = 32;
   localparam int STRIDE_W   = 32;
   localparam int OFF_W      = 6;
   localparam int CNT_W      = 22;
   localparam int WIDTH_BITS = 16;
   localparam int MAX_ROWS   = 64;
   localparam int ROWS_W     = $clog2(MAX_ROWS + 1);
   localparam int IDX_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int PROD_W     = WIDTH_BITS + ROWS_W;

   localparam logic [OFF_W-1:0] OFF_SRC     = 6'h00;
   localparam logic [OFF_W-1:0] OFF_DST     = 6'h08;
   localparam logic [OFF_W-1:0] OFF_WIDTH   = 6'h10;
   localparam logic [OFF_W-1:0] OFF_HEIGHT  = 6'h14;
   localparam logic [OFF_W-1:0] OFF_SSTRIDE = 6'h18;
   localparam logic [OFF_W-1:0] OFF_DSTRIDE = 6'h1C;
   localparam logic [OFF_W-1:0] OFF_START   = 6'h20;

   localparam logic [DATA_W-1:0] START_VALUE = 64'd1;

   localparam logic OP_READ  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic KIND_ACK = 1'b0;
   localparam logic KIND_CMD = 1'b1;

   localparam logic CSR_SRC_BASE = 1'b0;
   localparam logic CSR_DST_BASE = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_DECODE = 3'b010,
      ST_ISSUE  = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      OUT_ACK   = 2'd0,
      OUT_BURST = 2'd1,
      OUT_ROW   = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        decode;
      logic        load_out;
      out_sel_type out_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic start;
      logic burst;
      logic rows_zero;
      logic last_row;
      logic out_free;
   } dp_status_type;

endpackage

@@ rtl/s2dma_ctrl.sv @@
// Controller state machine of the strided 2D DMA command generator.
// Depends on s2dma_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "strided_2d_dma_command_generator_assert.svh"

module s2dma_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  s2dma_pkg::dp_status_type status,
   output s2dma_pkg::dp_cmd_type    cmd
);
   import s2dma_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      issue_go;
   logic      final_item;
   logic      req_fire;

   // The item being issued is the final one of its access unless rows remain.
   assign final_item = !status.start || status.burst || status.rows_zero || status.last_row;
   assign issue_go   = (state_ff == ST_ISSUE) && status.out_free;
   assign req_tready = (state_ff == ST_IDLE) || (issue_go && final_item);
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      cmd.capture  = req_fire;
      cmd.decode   = (state_ff == ST_DECODE);
      cmd.load_out = issue_go;
      if (!status.start) begin
         cmd.out_sel = OUT_ACK;
      end else if (status.burst) begin
         cmd.out_sel = OUT_BURST;
      end else if (status.rows_zero) begin
         cmd.out_sel = OUT_ACK;
      end else begin
         cmd.out_sel = OUT_ROW;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_ISSUE;
         end
         ST_ISSUE: begin
            if (issue_go && final_item) begin
               state_in = req_fire ? ST_DECODE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `S2DMA_ASSERT_NEXT(a_accept_decodes, clock, reset, req_fire, state_ff == ST_DECODE)
   `S2DMA_ASSERT_NEXT(a_decode_issues, clock, reset, state_ff == ST_DECODE, state_ff == ST_ISSUE)
   `S2DMA_ASSERT_IMPL(a_load_only_issue, clock, reset, cmd.load_out, state_ff == ST_ISSUE)

endmodule

@@ rtl/s2dma_datapath.sv @@
// Datapath of the strided 2D DMA command generator: job registers, region bases,
// address accumulators and the result register. Depends on s2dma_pkg and the macro header.
`timescale 1ns / 1ps
`include "strided_2d_dma_command_generator_assert.svh"

module s2dma_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  s2dma_pkg::dp_cmd_type              cmd,
   output s2dma_pkg::dp_status_type           status,
   input  logic                               req_operation,
   input  logic [s2dma_pkg::OFF_W-1:0]        req_register_offset,
   input  logic [s2dma_pkg::DATA_W-1:0]       req_write_data,
   input  logic                               req_wide_access,
   input  logic                               csr_write,
   input  logic                               csr_index,
   input  logic [s2dma_pkg::ADDR_W-1:0]       csr_data,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic                               rsp_kind,
   output logic [s2dma_pkg::ADDR_W-1:0]       rsp_read_address,
   output logic [s2dma_pkg::ADDR_W-1:0]       rsp_write_address,
   output logic [s2dma_pkg::CNT_W-1:0]        rsp_byte_count,
   output logic                               rsp_last
);
   import s2dma_pkg::*;

   // Captured access.
   logic                  op_ff, op_in;
   logic [OFF_W-1:0]      off_ff, off_in;
   logic [DATA_W-1:0]     val_ff, val_in;
   // Job registers and region bases.
   logic [ADDR_W-1:0]     src_addr_ff, src_addr_in;
   logic [ADDR_W-1:0]     dst_addr_ff, dst_addr_in;
   logic [WIDTH_BITS-1:0] row_width_ff, row_width_in;
   logic [ROWS_W-1:0]     row_count_ff, row_count_in;
   logic [STRIDE_W-1:0]   src_stride_ff, src_stride_in;
   logic [STRIDE_W-1:0]   dst_stride_ff, dst_stride_in;
   logic [ADDR_W-1:0]     src_base_ff, src_base_in;
   logic [ADDR_W-1:0]     dst_base_ff, dst_base_in;
   // Decoded job.
   logic                  start_ff, start_in;
   logic                  burst_ff, burst_in;
   logic [ADDR_W-1:0]     rd_acc_ff, rd_acc_in;
   logic [ADDR_W-1:0]     wr_acc_ff, wr_acc_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [IDX_W-1:0]      row_idx_ff, row_idx_in;
   // Result register.
   logic                  out_valid_ff, out_valid_in;
   logic                  kind_ff, kind_in;
   logic [ADDR_W-1:0]     rd_out_ff, rd_out_in;
   logic [ADDR_W-1:0]     wr_out_ff, wr_out_in;
   logic [CNT_W-1:0]      cnt_out_ff, cnt_out_in;
   logic                  last_out_ff, last_out_in;

   logic                  out_free;
   logic                  last_row;
   logic [CNT_W-1:0]      burst_cnt;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign last_row  = (ROWS_W'(row_idx_ff) + ROWS_W'(1)) == row_count_ff;
   assign burst_cnt = (|prod_ff[PROD_W-1:CNT_W]) ? {CNT_W{1'b1}} : prod_ff[CNT_W-1:0];

   assign status.start     = start_ff;
   assign status.burst     = burst_ff;
   assign status.rows_zero = (row_count_ff == '0);
   assign status.last_row  = last_row;
   assign status.out_free  = out_free;

   always_comb begin
      op_in         = op_ff;
      off_in        = off_ff;
      val_in        = val_ff;
      src_addr_in   = src_addr_ff;
      dst_addr_in   = dst_addr_ff;
      row_width_in  = row_width_ff;
      row_count_in  = row_count_ff;
      src_stride_in = src_stride_ff;
      dst_stride_in = dst_stride_ff;
      src_base_in   = src_base_ff;
      dst_base_in   = dst_base_ff;
      start_in      = start_ff;
      burst_in      = burst_ff;
      rd_acc_in     = rd_acc_ff;
      wr_acc_in     = wr_acc_ff;
      prod_in       = prod_ff;
      row_idx_in    = row_idx_ff;
      out_valid_in  = out_valid_ff;
      kind_in       = kind_ff;
      rd_out_in     = rd_out_ff;
      wr_out_in     = wr_out_ff;
      cnt_out_in    = cnt_out_ff;
      last_out_in   = last_out_ff;

      if (csr_write) begin
         if (csr_index == CSR_SRC_BASE) begin
            src_base_in = csr_data;
         end else begin
            dst_base_in = csr_data;
         end
      end

      // A narrow access only carries the low word.
      if (cmd.capture) begin
         op_in  = req_operation;
         off_in = req_register_offset;
         val_in = req_wide_access ? req_write_data
                                  : {{(DATA_W-NARROW_W){1'b0}}, req_write_data[NARROW_W-1:0]};
      end

      if (cmd.decode) begin
         if (op_ff == OP_WRITE) begin
            case (off_ff)
               OFF_SRC: begin
                  src_addr_in = val_ff;
               end
               OFF_DST: begin
                  dst_addr_in = val_ff;
               end
               OFF_WIDTH: begin
                  row_width_in = (|val_ff[DATA_W-1:WIDTH_BITS]) ? {WIDTH_BITS{1'b1}}
                                                               : val_ff[WIDTH_BITS-1:0];
               end
               OFF_HEIGHT: begin
                  row_count_in = (val_ff > DATA_W'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS)
                                                             : val_ff[ROWS_W-1:0];
               end
               OFF_SSTRIDE: begin
                  src_stride_in = val_ff[STRIDE_W-1:0];
               end
               OFF_DSTRIDE: begin
                  dst_stride_in = val_ff[STRIDE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         start_in   = (op_ff == OP_WRITE) && (off_ff == OFF_START) && (val_ff == START_VALUE);
         burst_in   = (src_stride_ff == STRIDE_W'(row_width_ff))
                   && (dst_stride_ff == STRIDE_W'(row_width_ff));
         rd_acc_in  = src_addr_ff - src_base_ff;
         wr_acc_in  = dst_addr_ff - dst_base_ff;
         prod_in    = PROD_W'(row_width_ff) * PROD_W'(row_count_ff);
         row_idx_in = '0;
      end

      if (cmd.load_out) begin
         out_valid_in = 1'b1;
         case (cmd.out_sel)
            OUT_BURST: begin
               kind_in     = KIND_CMD;
               rd_out_in   = rd_acc_ff;
               wr_out_in   = wr_acc_ff;
               cnt_out_in  = burst_cnt;
               last_out_in = 1'b1;
            end
            OUT_ROW: begin
               kind_in     = KIND_CMD;
               rd_out_in   = rd_acc_ff;
               wr_out_in   = wr_acc_ff;
               cnt_out_in  = CNT_W'(row_width_ff);
               last_out_in = last_row;
               rd_acc_in   = rd_acc_ff + ADDR_W'(src_stride_ff);
               wr_acc_in   = wr_acc_ff + ADDR_W'(dst_stride_ff);
               row_idx_in  = row_idx_ff + IDX_W'(1);
            end
            default: begin
               kind_in     = KIND_ACK;
               rd_out_in   = '0;
               wr_out_in   = '0;
               cnt_out_in  = '0;
               last_out_in = 1'b1;
            end
         endcase
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_addr_ff   <= '0;
         dst_addr_ff   <= '0;
         row_width_ff  <= '0;
         row_count_ff  <= '0;
         src_stride_ff <= '0;
         dst_stride_ff <= '0;
         src_base_ff   <= '0;
         dst_base_ff   <= '0;
         start_ff      <= 1'b0;
         burst_ff      <= 1'b0;
         row_idx_ff    <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         src_addr_ff   <= src_addr_in;
         dst_addr_ff   <= dst_addr_in;
         row_width_ff  <= row_width_in;
         row_count_ff  <= row_count_in;
         src_stride_ff <= src_stride_in;
         dst_stride_ff <= dst_stride_in;
         src_base_ff   <= src_base_in;
         dst_base_ff   <= dst_base_in;
         start_ff      <= start_in;
         burst_ff      <= burst_in;
         row_idx_ff    <= row_idx_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      off_ff      <= off_in;
      val_ff      <= val_in;
      rd_acc_ff   <= rd_acc_in;
      wr_acc_ff   <= wr_acc_in;
      prod_ff     <= prod_in;
      kind_ff     <= kind_in;
      rd_out_ff   <= rd_out_in;
      wr_out_ff   <= wr_out_in;
      cnt_out_ff  <= cnt_out_in;
      last_out_ff <= last_out_in;
   end

   assign rsp_tvalid        = out_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_read_address  = rd_out_ff;
   assign rsp_write_address = wr_out_ff;
   assign rsp_byte_count    = cnt_out_ff;
   assign rsp_last          = last_out_ff;

   `S2DMA_ASSERT_IMPL(a_load_into_free_slot, clock, reset, cmd.load_out,
                      !out_valid_ff || rsp_tready)
   `S2DMA_ASSERT_IMPL(a_row_in_range, clock, reset, cmd.load_out && cmd.out_sel == OUT_ROW,
                      ROWS_W'(row_idx_ff) < row_count_ff)
   `S2DMA_ASSERT_NEXT(a_load_shows_item, clock, reset, cmd.load_out, out_valid_ff)

endmodule

@@ rtl/strided_2d_dma_command_generator.sv @@
// Top level of the strided 2D DMA command generator: packs the stream channels and
// joins the controller and the datapath. Depends on s2dma_pkg, s2dma_ctrl, s2dma_datapath.
`timescale 1ns / 1ps

// Each item on the req_ channel is one register bus access. Writes set the source
// and destination addresses, row width, row count and the two strides; a write of 1
// to the start offset turns the stored job into transfer commands on the rsp_ channel.
// Every other access returns one plain acknowledge item with rsp_tlast set.
// The csr_ channel writes the two region bases, which are subtracted from the stored
// addresses to form local addresses; it is always ready. The user must write it only
// while idle; the block does not enforce this. Each access is captured, then decoded
// into the job state, then loaded into the single result register the controller
// sequences through; a row job issues one row command per cycle while the receiver
// takes them.
// A new access is accepted in the cycle the final result of the previous one is
// loaded, so a waiting result does not hold off the next decode.
// When the receiver stalls, the result register holds its item and row issue pauses.
// Reset clears the job registers, the region bases and the result channel.

module strided_2d_dma_command_generator (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [71:0]  req_tdata,   // register_offset, write_data, zero fill
   input  logic [1:0]   req_tuser,   // operation, wide_access
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [151:0] rsp_tdata,   // read_address, write_address, byte_count, zero fill
   output logic [0:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [63:0]  csr_data
);
   import s2dma_pkg::*;

   dp_cmd_type         cmd;
   dp_status_type      status;
   logic               rsp_kind;
   logic [ADDR_W-1:0]  rsp_read_address;
   logic [ADDR_W-1:0]  rsp_write_address;
   logic [CNT_W-1:0]   rsp_byte_count;

   assign csr_ready = 1'b1;

   s2dma_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   s2dma_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_tuser[0]),
      .req_register_offset (req_tdata[OFF_W-1:0]),
      .req_write_data      (req_tdata[OFF_W+DATA_W-1:OFF_W]),
      .req_wide_access     (req_tuser[1]),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_tready          (rsp_tready),
      .rsp_kind            (rsp_kind),
      .rsp_read_address    (rsp_read_address),
      .rsp_write_address   (rsp_write_address),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_last            (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, rsp_byte_count, rsp_write_address, rsp_read_address};
   assign rsp_tuser = rsp_kind;

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the strided 2D DMA command generator.
// Drives register bus accesses and region base writes, predicts every result item.
// Depends on s2dma_pkg and strided_2d_dma_command_generator.
`timescale 1ns / 1ps

module tb_top;
   import s2dma_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DIRECTED_N = 25;
   localparam int PHASE_ITEMS = 135;

   typedef struct packed {
      logic                kind;
      logic [ADDR_W-1:0]   read_address;
      logic [ADDR_W-1:0]   write_address;
      logic [CNT_W-1:0]    byte_count;
      logic                last;
   } dma_result_type;

   typedef struct packed {
      logic              op;
      logic [OFF_W-1:0]  off;
      logic [DATA_W-1:0] data;
      logic              wide;
      logic              typed;
      dma_result_type    want;
   } access_row_type;

   localparam dma_result_type ACK_ONLY    = '{KIND_ACK, 64'd0, 64'd0, 22'd0, 1'b1};
   localparam dma_result_type EMPTY_BURST = '{KIND_CMD, 64'd0, 64'd0, 22'd0, 1'b1};

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [71:0]  req_tdata = '0;   // register_offset, write_data, zero fill
   logic [1:0]   req_tuser = '0;   // operation, wide_access
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [151:0] rsp_tdata;        // read_address, write_address, byte_count, zero fill
   logic [0:0]   rsp_tuser;        // kind
   logic         rsp_tlast;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [63:0]  csr_data = '0;

   strided_2d_dma_command_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // Job registers and region bases as the block should hold them.
   logic [ADDR_W-1:0]     job_src, job_dst, src_base, dst_base;
   logic [WIDTH_BITS-1:0] job_width;
   logic [ROWS_W-1:0]     job_rows;
   logic [STRIDE_W-1:0]   job_sstride, job_dstride;

   dma_result_type pending_results[$];
   dma_result_type planned_results[$];
   int          mismatch_count = 0;
   int          items_sent = 0;
   bit          timed_out = 1'b0;
   bit          src_idle_en = 1'b0;
   bit          sink_idle_en = 1'b0;
   int          sink_stall_left = 0;

   access_row_type directed_rows [DIRECTED_N] = '{
      '{OP_WRITE, OFF_START,   64'd1,                  1'b0, 1'b1, EMPTY_BURST},
      '{OP_READ,  OFF_SRC,     64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ACK_ONLY},
      '{OP_READ,  OFF_START,   64'd1,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_WIDTH,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_HEIGHT,  64'h0000_0001_0000_0000, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_SRC,     64'hFFFF_FFFF_FFFF_FFF0, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_DST,     64'hDEAD_BEEF_8000_0000, 1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_SSTRIDE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_DSTRIDE, 64'h0000_0001_0000_0040, 1'b1, 1'b1, ACK_ONLY},
      // Narrow start: the upper half of the data is dropped, so this is a real start.
      '{OP_WRITE, OFF_START,   64'hFFFF_FFFF_0000_0001, 1'b0, 1'b0, ACK_ONLY},
      '{OP_WRITE, OFF_SSTRIDE, 64'h0000_0000_0000_FFFF, 1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_DSTRIDE, 64'h0000_0000_0000_FFFF, 1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_START,   64'd1,                  1'b1, 1'b0, ACK_ONLY},
      '{OP_WRITE, OFF_START,   64'd2,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_START,   64'h0000_0001_0000_0001, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, 6'h3F,       64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ACK_ONLY},
      '{OP_WRITE, 6'h04,       64'd1,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_HEIGHT,  64'd0,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_SSTRIDE, 64'd3,                  1'b0, 1'b1, ACK_ONLY},
      // Row mode with no rows still returns a plain acknowledge.
      '{OP_WRITE, OFF_START,   64'd1,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_WIDTH,   64'd0,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_SSTRIDE, 64'd0,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_DSTRIDE, 64'd0,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_HEIGHT,  64'd5,                  1'b0, 1'b1, ACK_ONLY},
      '{OP_WRITE, OFF_START,   64'd1,                  1'b0, 1'b0, ACK_ONLY}
   };

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Applies one bus access to the job registers and lists the items it should produce.
   function automatic void plan_transfers(input logic op, input logic [OFF_W-1:0] off,
                                          input logic [DATA_W-1:0] data, input logic wide);
      logic [63:0] val, rd, wr, total, yy;
      dma_result_type item;
      val = wide ? data : {32'd0, data[31:0]};
      planned_results.delete();
      if (op == OP_WRITE) begin
         case (off)
            OFF_SRC:     job_src = val;
            OFF_DST:     job_dst = val;
            OFF_WIDTH:   job_width = (val > (64'd1 << WIDTH_BITS) - 64'd1) ? '1 : val[WIDTH_BITS-1:0];
            OFF_HEIGHT:  job_rows = (val > 64'(MAX_ROWS)) ? ROWS_W'(MAX_ROWS) : val[ROWS_W-1:0];
            OFF_SSTRIDE: job_sstride = val[STRIDE_W-1:0];
            OFF_DSTRIDE: job_dstride = val[STRIDE_W-1:0];
            OFF_START: begin
               if (val == START_VALUE) begin
                  rd = job_src - src_base;
                  wr = job_dst - dst_base;
                  if (64'(job_sstride) == 64'(job_width) && 64'(job_dstride) == 64'(job_width)) begin
                     total = 64'(job_width) * 64'(job_rows);
                     item = '{KIND_CMD, rd, wr,
                              (total > 64'h3F_FFFF) ? 22'h3F_FFFF : total[CNT_W-1:0], 1'b1};
                     planned_results.push_back(item);
                  end else begin
                     for (int y = 0; y < int'(job_rows); y++) begin
                        yy = 64'(y);
                        item = '{KIND_CMD, rd + yy * 64'(job_sstride),
                                 wr + yy * 64'(job_dstride), CNT_W'(job_width),
                                 (y == int'(job_rows) - 1)};
                        planned_results.push_back(item);
                     end
                  end
               end
            end
            default: ;
         endcase
      end
      if (planned_results.size() == 0)
         planned_results.push_back(ACK_ONLY);
   endfunction

   // Presents one access, waits for its handshake and books the expected items.
   // The caller is at a rising edge; tvalid is left high on return.
   task automatic send_access(input logic op, input logic [OFF_W-1:0] off,
                              input logic [DATA_W-1:0] data, input logic wide,
                              input logic typed = 1'b0, input dma_result_type want = ACK_ONLY);
      int gap;
      if (src_idle_en && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 11);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, data, off};
      req_tuser  <= {wide, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      plan_transfers(op, off, data, wide);
      items_sent++;
      if (typed)
         pending_results.push_back(want);
      else
         foreach (planned_results[i]) pending_results.push_back(planned_results[i]);
   endtask

   // Holds the sender until every booked item has come back.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_region_base(input logic idx, input logic [63:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SRC_BASE)
         src_base = value;
      else
         dst_base = value;
   endtask

   // Most jobs are small; a few use the full row count or saturating sizes.
   task automatic issue_random_job();
      logic [63:0] v;
      if ($urandom_range(0, 3) != 0)
         send_access(OP_WRITE, OFF_SRC, rand64(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0)
         send_access(OP_WRITE, OFF_DST, rand64(), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 7))
            0:       v = rand64();
            1:       v = 64'hFFFF;
            2:       v = 64'd0;
            default: v = 64'($urandom_range(1, 300));
         endcase
         send_access(OP_WRITE, OFF_WIDTH, v, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) != 0) begin
         case ($urandom_range(0, 11))
            0:       v = rand64();
            1:       v = 64'(MAX_ROWS);
            2:       v = 64'd0;
            3:       v = 64'($urandom_range(MAX_ROWS - 2, MAX_ROWS + 3));
            default: v = 64'($urandom_range(1, 6));
         endcase
         send_access(OP_WRITE, OFF_HEIGHT, v, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 2) == 0) begin
         // Both strides equal to the width select the single burst.
         send_access(OP_WRITE, OFF_SSTRIDE, 64'(job_width), 1'b0);
         send_access(OP_WRITE, OFF_DSTRIDE, 64'(job_width), 1'b0);
      end else begin
         v = $urandom_range(0, 1) ? 64'($urandom_range(0, 400)) : rand64();
         send_access(OP_WRITE, OFF_SSTRIDE, v, 1'($urandom_range(0, 1)));
         v = $urandom_range(0, 1) ? 64'($urandom_range(0, 400)) : rand64();
         send_access(OP_WRITE, OFF_DSTRIDE, v, 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0)
         send_access(OP_WRITE, OFF_START, {$urandom, 32'd1}, 1'b0);
      else
         send_access(OP_WRITE, OFF_START, 64'd1, 1'($urandom_range(0, 1)));
   endtask

   task automatic run_random_phase(input int items);
      int start_count;
      logic [63:0] v;
      start_count = items_sent;
      while (items_sent - start_count < items) begin
         case ($urandom_range(0, 9))
            7: begin
               send_access(OP_READ, OFF_W'($urandom_range(0, 63)), rand64(),
                           1'($urandom_range(0, 1)));
            end
            8: begin
               send_access(OP_WRITE, OFF_W'($urandom_range(0, 63)), rand64(),
                           1'($urandom_range(0, 1)));
            end
            9: begin
               case ($urandom_range(0, 3))
                  0:       v = 64'd1;
                  1:       v = 64'd0;
                  2:       v = 64'h0000_0001_0000_0001;
                  default: v = rand64();
               endcase
               send_access(OP_WRITE, OFF_START, v, 1'($urandom_range(0, 1)));
            end
            default: begin
               issue_random_job();
            end
         endcase
         if ($urandom_range(0, 49) == 0) drain_results();
      end
   endtask

   // Reconfigure only while the block is quiet.
   task automatic set_region_bases(input logic [63:0] src_value, input logic [63:0] dst_value);
      drain_results();
      repeat (4) @(posedge clock);
      write_region_base(CSR_SRC_BASE, src_value);
      @(posedge clock);
      write_region_base(CSR_DST_BASE, dst_value);
      @(posedge clock);
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (sink_stall_left > 0) begin
         sink_stall_left <= sink_stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
         sink_stall_left <= $urandom_range(1, 11) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      dma_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result item with nothing expected: kind %0b tdata 0x%0h", rsp_tuser[0], rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("kind", 64'(want.kind), 64'(rsp_tuser[0]));
            check_field("read_address", want.read_address, rsp_tdata[63:0]);
            check_field("write_address", want.write_address, rsp_tdata[127:64]);
            check_field("byte_count", 64'(want.byte_count), 64'(rsp_tdata[149:128]));
            check_field("last", 64'(want.last), 64'(rsp_tlast));
         end
      end
   end

   initial begin
      int idle_cycles;
      job_src = '0; job_dst = '0; job_width = '0; job_rows = '0;
      job_sstride = '0; job_dstride = '0; src_base = '0; dst_base = '0;
      fork
         begin
            repeat (3) @(posedge clock);
            reset <= 1'b0;
            for (int i = 0; i < DIRECTED_N; i++)
               send_access(directed_rows[i].op, directed_rows[i].off, directed_rows[i].data,
                           directed_rows[i].wide, directed_rows[i].typed, directed_rows[i].want);
            src_idle_en = 1'b1;
            sink_idle_en = 1'b1;
            set_region_bases('1, '1);
            run_random_phase(PHASE_ITEMS);
            set_region_bases(rand64(), rand64());
            run_random_phase(PHASE_ITEMS);
            set_region_bases('0, 64'h8000_0000_0000_0000);
            src_idle_en = 1'b0;
            sink_idle_en = 1'b0;
            run_random_phase(PHASE_ITEMS);
            drain_results();
            repeat (10) @(posedge clock);
            if (pending_results.size() != 0) begin
               $error("%0d expected result items never arrived", pending_results.size());
               mismatch_count++;
            end
         end
         begin
            idle_cycles = 0;
            while (idle_cycles < WATCHDOG_LIMIT) begin
               @(posedge clock);
               if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready))
                  idle_cycles = 0;
               else
                  idle_cycles++;
            end
            timed_out = 1'b1;
         end
      join_any
      if (timed_out) begin
         $display("tb_top failed");
      end else if (mismatch_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
